// ===== hdl/adam_optimizer_update_defines.svh =====
// Assertion macros shared by the Adam update block.
`ifndef ADAM_OPTIMIZER_UPDATE_DEFINES_SVH
`define ADAM_OPTIMIZER_UPDATE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define ADAM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adam assertion failed");
// Next-cycle implication checked outside reset.
`define ADAM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adam assertion failed");
`endif

// ===== hdl/adam_pkg.sv =====
// Package with types and constants of the Adam update block.
package adam_pkg;
  localparam int unsigned IDX_W = 12;
  localparam int unsigned PARAM_COUNT = 4096;
  localparam int unsigned ADDR_W = $clog2(PARAM_COUNT);
  localparam logic [23:0] POWER_ONE = 24'hFFFFFF;
  localparam logic [23:0] LR_RESET = 24'd16777;
  localparam logic [23:0] B1_RESET = 24'd15099494;
  localparam logic [23:0] B2_RESET = 24'd16760439;
  localparam logic [15:0] EPS_RESET = 16'd1;

  localparam logic [1:0] REG_LR = 2'd0;
  localparam logic [1:0] REG_B1 = 2'd1;
  localparam logic [1:0] REG_B2 = 2'd2;
  localparam logic [1:0] REG_EPS = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_BLEND, ST_MOM, ST_DIVM, ST_DIVV, ST_SQRT,
    ST_STEPNUM, ST_DIVS, ST_DONE
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic        go;
    logic [63:0] num;
    logic [63:0] den;
  } div_req_t;
endpackage

// ===== hdl/adam_optimizer_update.sv =====
// Adam update: moment stores in block RAM, shared divider and square root.
// Once a transaction is taken the block reads the moments, blends them and writes
// them back, divides for the corrected first and second moments, takes the 24-bit
// square root, forms the step numerator and runs the step division; out_valid is
// registered from the done state. busy drops with out_valid, so a new transaction
// is taken only after the previous result. After reset a clearing pass zeroes both
// moment memories with busy high; configuration writes are taken as ever.
module adam_optimizer_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] in_param_index,
  input  logic signed [31:0] in_gradient,
  input  logic signed [31:0] in_weight_in,
  input  logic        in_first_of_pass,
  output logic        out_valid,
  output logic [11:0] out_index_out,
  output logic signed [31:0] out_weight_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
`include "adam_optimizer_update_defines.svh"

  // Configuration registers.
  logic [23:0] lr_r, b1_r, b2_r;
  logic [15:0] eps_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= adam_pkg::LR_RESET;
      b1_r <= adam_pkg::B1_RESET;
      b2_r <= adam_pkg::B2_RESET;
      eps_r <= adam_pkg::EPS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        adam_pkg::REG_LR:  lr_r <= cfg_data;
        adam_pkg::REG_B1:  b1_r <= cfg_data;
        adam_pkg::REG_B2:  b2_r <= cfg_data;
        adam_pkg::REG_EPS: eps_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Moment memories, one read-modify-write per item.
  logic [31:0] mmem [adam_pkg::PARAM_COUNT];
  logic [31:0] vmem [adam_pkg::PARAM_COUNT];
  logic [31:0] mrd_r, vrd_r;
  logic        mem_we;
  logic [adam_pkg::ADDR_W-1:0] mem_wa;
  logic [31:0] mem_wm, mem_wv;

  adam_pkg::state_t st_r, st_nxt;
  logic [adam_pkg::ADDR_W:0] clr_r;
  logic [11:0] idx_r;
  logic signed [31:0] g_r, w_r;
  logic [23:0] p1_r, p2_r;
  logic signed [31:0] m_r;
  logic [31:0] v_r;
  logic [30:0] mhat_r;
  logic [63:0] pm_r, pv_r, pg_r;
  logic [31:0] gsq_r;
  logic [23:0] s_r;
  logic [47:0] sx_r, sr_r;
  logic [4:0]  sq_cnt_r;
  logic [55:0] num_r;
  logic signed [31:0] wout_r;
  logic        ovalid_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mmem[mem_wa] <= mem_wm;
      vmem[mem_wa] <= mem_wv;
    end
    mrd_r <= mmem[idx_r[adam_pkg::ADDR_W-1:0]];
    vrd_r <= vmem[idx_r[adam_pkg::ADDR_W-1:0]];
  end

  // Shared divider.
  adam_pkg::div_req_t dreq;
  logic        ddone;
  logic [63:0] dq;
  adam_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  // Blend arithmetic.
  logic [31:0] gmag;
  logic [24:0] omb1, omb2;
  logic signed [64:0] msum;
  logic [64:0] vsum, gsq_full;
  logic [63:0] mabs;
  logic [31:0] mnew_mag;
  logic signed [31:0] mnew;
  logic [31:0] vnew;
  logic [24:0] c1, c2;
  logic [15:0] eps_eff;
  logic [24:0] dsum;
  logic [47:0] stp;
  logic signed [49:0] stp_s;
  logic signed [49:0] wdiff;

  always_comb begin
    gmag = g_r[31] ? 32'(-g_r) : g_r;
    omb1 = 25'h1000000 - {1'b0, b1_r};
    omb2 = 25'h1000000 - {1'b0, b2_r};
    msum = 65'(signed'(pm_r)) + 65'(signed'(pg_r));
    mabs = msum[64] ? 64'(-msum) : msum[63:0];
    mnew_mag = 32'((mabs + 64'h800000) >> 24);
    mnew = msum[64] ? -signed'(mnew_mag) : signed'(mnew_mag);
    gsq_full = 65'(pg_r) + 65'h8000;
    // Second-moment blend: beta2*v from the memory plus (1-beta2)*gsq.
    vsum = 65'(pv_r) + 65'(64'(gsq_r) * 64'(omb2)) + 65'h800000;
    vnew = (vsum[64:24] > 41'hFFFFFFFF) ? 32'hFFFFFFFF : vsum[55:24];
    // A power of zero leaves a full 2^24 correction factor.
    c1 = 25'h1000000 - {1'b0, p1_r};
    c2 = 25'h1000000 - {1'b0, p2_r};
    eps_eff = (eps_r == '0) ? 16'd1 : eps_r;
    dsum = {1'b0, s_r} + {9'd0, eps_eff};
    stp = dq[47:0];
    stp_s = signed'({2'b00, stp});
    wdiff = 50'(w_r) - (m_r[31] ? -stp_s : stp_s);
  end

  // Next-state logic.
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      adam_pkg::ST_CLEAR: if (clr_r[adam_pkg::ADDR_W]) st_nxt = adam_pkg::ST_IDLE;
      adam_pkg::ST_IDLE:  if (start) st_nxt = adam_pkg::ST_READ;
      adam_pkg::ST_READ:  st_nxt = adam_pkg::ST_BLEND;
      adam_pkg::ST_BLEND: st_nxt = adam_pkg::ST_MOM;
      adam_pkg::ST_MOM:   st_nxt = adam_pkg::ST_DIVM;
      adam_pkg::ST_DIVM:  if (ddone) st_nxt = adam_pkg::ST_DIVV;
      adam_pkg::ST_DIVV:  if (ddone) st_nxt = adam_pkg::ST_SQRT;
      adam_pkg::ST_SQRT:  if (sq_cnt_r == 5'd0) st_nxt = adam_pkg::ST_STEPNUM;
      adam_pkg::ST_STEPNUM: st_nxt = adam_pkg::ST_DIVS;
      adam_pkg::ST_DIVS:  if (ddone) st_nxt = adam_pkg::ST_DONE;
      adam_pkg::ST_DONE:  st_nxt = adam_pkg::ST_IDLE;
      default:            st_nxt = adam_pkg::ST_IDLE;
    endcase
  end

  // Output / control decode.
  always_comb begin
    dreq = '0;
    mem_we = 1'b0;
    mem_wa = clr_r[adam_pkg::ADDR_W-1:0];
    mem_wm = '0;
    mem_wv = '0;
    unique case (st_r)
      adam_pkg::ST_CLEAR: mem_we = !clr_r[adam_pkg::ADDR_W];
      adam_pkg::ST_MOM: begin
        mem_we = 1'b1;
        mem_wa = idx_r[adam_pkg::ADDR_W-1:0];
        mem_wm = mnew;
        mem_wv = vnew;
        dreq.go = 1'b1;
        dreq.num = {8'd0, mnew[31] ? 32'(-mnew) : mnew, 24'd0};
        dreq.den = {39'd0, c1};
      end
      adam_pkg::ST_DIVM: if (ddone) begin
        dreq.go = 1'b1;
        dreq.num = {8'd0, v_r, 24'd0};
        dreq.den = {39'd0, c2};
      end
      adam_pkg::ST_STEPNUM: begin
        // Half the divisor is added first so the quotient rounds half up.
        dreq.go = 1'b1;
        dreq.num = {8'd0, num_r} + {32'd0, dsum, 7'd0};
        dreq.den = {31'd0, dsum, 8'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= adam_pkg::ST_CLEAR;
      clr_r <= '0;
      p1_r <= adam_pkg::POWER_ONE;
      p2_r <= adam_pkg::POWER_ONE;
      ovalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ovalid_r <= (st_r == adam_pkg::ST_DONE);
      if (st_r == adam_pkg::ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (st_r == adam_pkg::ST_IDLE && start && in_first_of_pass) begin
        p1_r <= 24'((48'(p1_r) * 48'(b1_r) + 48'h800000) >> 24);
        p2_r <= 24'((48'(p2_r) * 48'(b2_r) + 48'h800000) >> 24);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (st_r)
      adam_pkg::ST_IDLE: begin
        idx_r <= in_param_index;
        g_r <= in_gradient;
        w_r <= in_weight_in;
      end
      adam_pkg::ST_READ: begin
        pg_r <= 64'(gmag) * 64'(gmag);
      end
      adam_pkg::ST_BLEND: begin
        pm_r <= 64'(signed'(65'(signed'(mrd_r)) * 65'(signed'({1'b0, b1_r}))));
        gsq_r <= (gsq_full[64:16] > 49'hFFFFFFFF) ? 32'hFFFFFFFF : gsq_full[47:16];
        pg_r <= 64'(65'(signed'(g_r)) * 65'(signed'({1'b0, omb1})));
      end
      adam_pkg::ST_MOM: begin
        m_r <= mnew;
        v_r <= vnew;
      end
      adam_pkg::ST_DIVM: if (ddone) begin
        mhat_r <= (dq > 64'h7FFFFFFF) ? 31'h7FFFFFFF : dq[30:0];
      end
      adam_pkg::ST_DIVV: if (ddone) begin
        sx_r <= {(dq > 64'hFFFFFFFF) ? 32'hFFFFFFFF : dq[31:0], 16'd0};
        sr_r <= '0;
        s_r <= '0;
        sq_cnt_r <= 5'd24;
      end
      adam_pkg::ST_SQRT: begin
        if (sq_cnt_r != 5'd0) begin
          // Digit-by-digit root: one result bit per cycle.
          if ({sr_r[45:0], sx_r[47:46]} >= {22'd0, s_r, 2'b01}) begin
            sr_r <= {sr_r[45:0], sx_r[47:46]} - {22'd0, s_r, 2'b01};
            s_r <= {s_r[22:0], 1'b1};
          end else begin
            sr_r <= {sr_r[45:0], sx_r[47:46]};
            s_r <= {s_r[22:0], 1'b0};
          end
          sx_r <= {sx_r[45:0], 2'b00};
          sq_cnt_r <= sq_cnt_r - 5'd1;
        end
        num_r <= 56'(lr_r) * 56'(mhat_r);
      end
      adam_pkg::ST_DIVS: if (ddone) begin
        wout_r <= (wdiff > 50'sh7FFFFFFF) ? 32'sh7FFFFFFF :
                  (wdiff < -50'sh80000000) ? 32'sh80000000 : wdiff[31:0];
      end
      default: ;
    endcase
    // Second-moment products are formed beside the first-moment ones.
    if (st_r == adam_pkg::ST_BLEND) pv_r <= 64'(vrd_r) * 64'(b2_r);
  end

  assign busy = (st_r != adam_pkg::ST_IDLE);
  assign out_valid = ovalid_r;
  assign out_index_out = idx_r;
  assign out_weight_out = wout_r;

  `ADAM_ASSERT_IMP(a_no_start_when_busy, out_valid, st_r == adam_pkg::ST_IDLE)
  `ADAM_ASSERT_NXT(a_done_valid, st_r == adam_pkg::ST_DONE, out_valid)
  `ADAM_ASSERT_IMP(a_wr_only_mom, mem_we && st_r != adam_pkg::ST_CLEAR,
                   st_r == adam_pkg::ST_MOM)
endmodule

// ===== hdl/adam_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module adam_div (
  input  logic              clk,
  input  logic              rst_n,
  input  adam_pkg::div_req_t req,
  output logic              done,
  output logic [63:0]       quot
);
  logic [63:0] q_r, q_nxt, rem_r, rem_nxt, den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [64:0] trial;
  logic [63:0] q_iter, rem_iter;

  // One restoring step; its quotient is what the caller sees on the last step,
  // even when a new request is loaded in that same cycle.
  always_comb begin
    trial = {rem_r, q_r[63]};
    if (trial >= {1'b0, den_r}) begin
      rem_iter = 64'(trial - {1'b0, den_r});
      q_iter = {q_r[62:0], 1'b1};
    end else begin
      rem_iter = trial[63:0];
      q_iter = {q_r[62:0], 1'b0};
    end
  end

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (req.go) begin
      q_nxt = req.num;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = rem_iter;
      q_nxt = q_iter;
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (req.go) den_r <= req.den;
  end

  assign done = busy_r && (cnt_r == 7'd1);
  assign quot = q_iter;
endmodule

// ===== tb/sv/adam_optimizer_update_test.sv =====
// Self-checking testbench for the fixed-point Adam parameter update block.
module adam_optimizer_update_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected result of one update transaction.
  typedef struct {
    logic [11:0] index;
    logic [31:0] weight;
  } update_t;

  // Scoreboard: holds its own copy of the moment stores, the bias correction
  // powers and the coefficients, and predicts each result when an input is taken.
  class adam_scoreboard;
    logic [23:0] lr, b1, b2;
    logic [15:0] eps;
    logic signed [31:0] mom1 [adam_pkg::PARAM_COUNT];
    logic [31:0] mom2 [adam_pkg::PARAM_COUNT];
    logic [23:0] p1, p2;
    update_t pending[$];
    int errors;

    function void clear();
      lr = adam_pkg::LR_RESET; b1 = adam_pkg::B1_RESET; b2 = adam_pkg::B2_RESET;
      eps = adam_pkg::EPS_RESET;
      p1 = adam_pkg::POWER_ONE; p2 = adam_pkg::POWER_ONE;
      foreach (mom1[i]) begin
        mom1[i] = 0;
        mom2[i] = 0;
      end
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        adam_pkg::REG_LR:  lr = val;
        adam_pkg::REG_B1:  b1 = val;
        adam_pkg::REG_B2:  b2 = val;
        adam_pkg::REG_EPS: eps = val[15:0];
      endcase
    endfunction

    // Rounded Q0.24 product, half away from zero for the signed case.
    function automatic longint rnd24(longint x);
      if (x < 0) return -((-x + 64'd8388608) >>> 24);
      return (x + 64'd8388608) >>> 24;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_input(logic [11:0] idx, logic signed [31:0] g,
                             logic signed [31:0] w, logic first);
      longint mn, gl, dl, wo;
      longint unsigned gm, gsq, vn, c1, c2, mm, mh, vh, d, num, den, st;
      int slot;
      bit neg;
      update_t e;
      slot = idx % adam_pkg::PARAM_COUNT;
      gl = g;
      if (first) begin
        p1 = ((64'(p1) * b1) + 64'd8388608) >> 24;
        p2 = ((64'(p2) * b2) + 64'd8388608) >> 24;
      end
      mn = rnd24(longint'(b1) * longint'(mom1[slot]) + (longint'(1 << 24) - b1) * gl);
      if (mn > 64'sh7FFFFFFF) mn = 64'sh7FFFFFFF;
      if (mn < -64'sh80000000) mn = -64'sh80000000;
      mom1[slot] = mn;
      gm = (gl < 0) ? -gl : gl;
      gsq = (gm * gm + (1 << 15)) >> 16;
      if (gsq > 64'hFFFFFFFF) gsq = 64'hFFFFFFFF;
      vn = (64'(b2) * mom2[slot] + ((64'd1 << 24) - b2) * gsq + 64'd8388608) >> 24;
      if (vn > 64'hFFFFFFFF) vn = 64'hFFFFFFFF;
      mom2[slot] = vn;
      c1 = (64'd1 << 24) - p1;
      c2 = (64'd1 << 24) - p2;
      neg = mn < 0;
      mm = neg ? -mn : mn;
      mh = (mm << 24) / c1;
      if (mh > 64'h7FFFFFFF) mh = 64'h7FFFFFFF;
      vh = (vn << 24) / c2;
      if (vh > 64'hFFFFFFFF) vh = 64'hFFFFFFFF;
      d = isqrt(vh << 16) + ((eps != 0) ? eps : 1);
      num = 64'(lr) * mh;
      den = d << 8;
      st = (num + (den >> 1)) / den;
      dl = neg ? -longint'(st) : longint'(st);
      wo = longint'(w) - dl;
      if (wo > 64'sh7FFFFFFF) wo = 64'sh7FFFFFFF;
      if (wo < -64'sh80000000) wo = -64'sh80000000;
      e.index = idx;
      e.weight = wo[31:0];
      pending = {pending, e};
    endfunction

    function void check_result(logic [11:0] idx, logic [31:0] w);
      update_t e;
      if (pending.size() == 0) begin
        $error("unexpected result index %0d weight %h", idx, w);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (idx !== e.index) begin
        $error("index_out expected %0d actual %0d", e.index, idx);
        errors++;
      end
      if (w !== e.weight) begin
        $error("weight_out expected %h actual %h", e.weight, w);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0, start = 0, busy, out_valid;
  logic [11:0] in_param_index = 0, out_index_out;
  logic signed [31:0] in_gradient = 0, in_weight_in = 0, out_weight_out;
  logic in_first_of_pass = 0, cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [23:0] cfg_data = 0;

  adam_scoreboard sb;
  int idle_cycles;
  bit quiet_phase;
  localparam int WATCHDOG = 20000;

  always #1 clk = ~clk;

  adam_optimizer_update dut (.*);

  // Results cannot be held off, so every strobe is checked at once.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_index_out, out_weight_out);
  end

  // Watchdog: cycles without an accepted transaction, a result or a configuration
  // write. The clearing pass and one full update fit well within the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Drive one update transaction and hold it until the block takes it.
  // start stays high afterwards until the next transaction, an idle burst or a drain.
  task automatic send_update(logic [11:0] idx, logic [31:0] g, logic [31:0] w,
                             logic first);
    int gap;
    cfg_we <= 0;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_param_index <= idx;
    in_gradient <= g;
    in_weight_in <= w;
    in_first_of_pass <= first;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_input(idx, g, w, first);
  endtask

  // Wait until every prediction has been matched, then let the block settle.
  task automatic drain();
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // The write enable is dropped by the next update transaction.
  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  // Random gradient: mostly moderate, sometimes full range.
  function automatic logic [31:0] rand_grad();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      default: return $signed($urandom_range(0, 32'h1FFF)) - 32'sh1000;
    endcase
  endfunction

  // One pass over a small random block of parameters.
  task automatic random_pass(int count);
    logic [11:0] base;
    base = $urandom();
    for (int i = 0; i < count; i++) begin
      send_update(($urandom_range(0, 7) == 0) ? 12'($urandom()) : base + 12'(i % 8),
                  rand_grad(), $urandom(), (i == 0) || ($urandom_range(0, 31) == 0));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    quiet_phase = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;

    // Directed: no pass started yet, so bias correction saturates.
    send_update(12'd0, 32'sh00010000, 32'sh00010000, 1'b0);
    send_update(12'hFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
    // Normal first pass with gradient and weight extremes.
    send_update(12'd5, 32'sh7FFFFFFF, 32'sh80000000, 1'b1);
    send_update(12'd5, 32'sh80000000, 32'sh7FFFFFFF, 1'b0);
    send_update(12'd6, 32'sh0, 32'sh0, 1'b0);
    send_update(12'd7, -32'sd1, 32'sh12345678, 1'b0);
    send_update(12'd5, 32'sh00008000, -32'sd5, 1'b1);
    drain();

    // Epsilon zero must act as one LSB; extreme coefficients.
    write_reg(adam_pkg::REG_EPS, 24'd0);
    write_reg(adam_pkg::REG_LR, 24'hFFFFFF);
    send_update(12'd9, 32'sh00020000, 32'sh0, 1'b1);
    send_update(12'd9, -32'sh00020000, 32'sh80000000, 1'b0);
    drain();
    write_reg(adam_pkg::REG_B1, 24'd0);
    write_reg(adam_pkg::REG_B2, 24'd0);
    write_reg(adam_pkg::REG_EPS, 24'hFFFF);
    send_update(12'd10, 32'sh7FFFFFFF, 32'sh0, 1'b1);
    send_update(12'd10, 32'sh00001000, 32'sh7FFFFFFF, 1'b1);
    drain();
    write_reg(adam_pkg::REG_B1, 24'hFFFFFF);
    write_reg(adam_pkg::REG_B2, 24'hFFFFFF);
    write_reg(adam_pkg::REG_LR, 24'd0);
    send_update(12'd11, 32'sh00050000, 32'sh00010000, 1'b1);
    drain();

    // Random phases, each with its own coefficient setting.
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 12) quiet_phase = 1;
      if (ph == 0) begin
        write_reg(adam_pkg::REG_LR, adam_pkg::LR_RESET);
        write_reg(adam_pkg::REG_B1, adam_pkg::B1_RESET);
        write_reg(adam_pkg::REG_B2, adam_pkg::B2_RESET);
        write_reg(adam_pkg::REG_EPS, 24'(adam_pkg::EPS_RESET));
      end else begin
        write_reg(adam_pkg::REG_LR, $urandom_range(0, 3) == 0 ?
                  24'($urandom()) : 24'($urandom_range(0, 300000)));
        write_reg(adam_pkg::REG_B1, $urandom_range(0, 3) == 0 ?
                  24'($urandom()) : 24'($urandom_range(14000000, 16777215)));
        write_reg(adam_pkg::REG_B2, $urandom_range(0, 3) == 0 ?
                  24'($urandom()) : 24'($urandom_range(16500000, 16777215)));
        write_reg(adam_pkg::REG_EPS, 24'($urandom_range(0, 65535)));
      end
      for (int k = 0; k < 5; k++) random_pass($urandom_range(7, 13));
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
